/* rtl/core/mspg_pkg.sv */
// Shared types and constants for the multichannel servo pulse generator.
package mspg_pkg;

  localparam int unsigned PULSE_W   = 15;
  localparam int unsigned COUNT_W   = 8;
  localparam int unsigned SLOT_W    = 4;
  localparam int unsigned CFG_IDX_W = 2;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_PULSE  = 2'd0,
    CFG_MAX_PULSE  = 2'd1,
    CFG_FRAME_SYNC = 2'd2,
    CFG_ACTIVE     = 2'd3
  } cfg_idx_t;

  // item actions
  localparam logic ACT_TICK  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  localparam logic [PULSE_W-1:0] MIN_PULSE_RST  = 15'd750;
  localparam logic [PULSE_W-1:0] MAX_PULSE_RST  = 15'd2250;
  localparam logic [COUNT_W-1:0] FRAME_SYNC_RST = 8'd62;
  localparam logic [7:0]         ACTIVE_RST     = 8'd1;

  // values a channel entry holds until first written
  localparam logic [COUNT_W-1:0] COUNT_RST   = 8'd11;
  localparam logic [COUNT_W-1:0] PRELOAD_RST = 8'd87;

  localparam logic [3:0] PULSE_BIAS = 4'd8;

  // one channel entry in the timing memory
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [COUNT_W-1:0] preload;
  } slot_entry_t;

  // result word
  typedef struct packed {
    logic              pin_level;
    logic [SLOT_W-1:0] current_slot;
  } result_t;

endpackage

/* rtl/core/multichannel_servo_pulse_generator_top.sv */
// Servo pulse sequencer: timing memory, slot timer and buffered result port.
// A result word is registered in the output register, or in the skid word while the output stalls.
// Throughput: one word per cycle while in_ready is high; the slot entry is prefetched from the
//   one-port-read timing memory, and a write just made to the live entry is forwarded.
// Output register plus one skid word, so input keeps flowing for one stalled word; in the
//   cycle the skid word moves to the output register, input is held.
// Reset (rst, synchronous, active high) restores registers and slot state; channel
//   entries read as count 11 / preload 87 until written (per-entry valid bits, no sweep).
module multichannel_servo_pulse_generator_top
  import mspg_pkg::*;
#(
  parameter int unsigned CHANNELS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  // input word
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 action,
  input  logic [3:0]           channel,
  input  logic signed [15:0]   pulse_us,
  // result word
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 pin_level,
  output logic [SLOT_W-1:0]    current_slot,
  // configuration writes
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PULSE_W-1:0]   cfg_data
);

  localparam int unsigned AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned DEPTH = 1 << AW;

  // ---------------- configuration registers ----------------
  logic [PULSE_W-1:0] min_pulse_us;
  logic [PULSE_W-1:0] max_pulse_us;
  logic [COUNT_W-1:0] frame_sync_count;
  logic [7:0]         active_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_pulse_us     <= MIN_PULSE_RST;
      max_pulse_us     <= MAX_PULSE_RST;
      frame_sync_count <= FRAME_SYNC_RST;
      active_mask      <= ACTIVE_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MIN_PULSE:  min_pulse_us     <= cfg_data;
        CFG_MAX_PULSE:  max_pulse_us     <= cfg_data;
        CFG_FRAME_SYNC: frame_sync_count <= cfg_data[COUNT_W-1:0];
        CFG_ACTIVE:     active_mask      <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // ---------------- handshake ----------------
  logic in_acc;
  logic skid_valid;
  assign in_ready = !skid_valid;
  assign in_acc   = in_valid && in_ready;

  logic is_tick, is_write;
  assign is_tick  = in_acc && (action == ACT_TICK);
  assign is_write = in_acc && (action == ACT_WRITE) && (channel >= 4'd1)
                    && ({28'd0, channel} <= CHANNELS);

  // ---------------- width conversion for a write ----------------
  // clamp (min test first), remove the bias, saturate at zero
  logic signed [16:0] w_in, w_min, w_max, w_clamp, w_biased;
  logic [PULSE_W-1:0] w_u;
  slot_entry_t        wr_entry;
  logic [AW-1:0]      wr_addr;

  always_comb begin
    w_in  = {pulse_us[15], pulse_us};
    w_min = {2'b00, min_pulse_us};
    w_max = {2'b00, max_pulse_us};
    if (w_in < w_min)      w_clamp = w_min;
    else if (w_in > w_max) w_clamp = w_max;
    else                   w_clamp = w_in;
    w_biased = w_clamp - {13'd0, PULSE_BIAS};
    w_u      = w_biased[16] ? '0 : w_biased[PULSE_W-1:0];
    // count = w / 128; preload = 255 - 2*(w mod 128), which is a bit inversion
    wr_entry.count   = w_u[PULSE_W-1:7];
    wr_entry.preload = ~{w_u[6:0], 1'b0};
    wr_addr          = AW'(channel - 4'd1);
  end

  // ---------------- timing memory ----------------
  slot_entry_t     mem [DEPTH];
  logic [DEPTH-1:0] entry_vld;
  slot_entry_t     rd_data;
  logic [AW-1:0]   rd_addr;

  // forwarding of the last write, covers the read-before-write cycle
  logic            fwd_valid;
  logic [AW-1:0]   fwd_addr;
  slot_entry_t     fwd_data;

  logic [SLOT_W-1:0] slot_index;
  assign rd_addr = AW'(slot_index - 4'd1);

  always_ff @(posedge clk) begin
    if (is_write) mem[wr_addr] <= wr_entry;
    rd_data  <= mem[rd_addr];
    fwd_addr <= wr_addr;
    fwd_data <= wr_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_vld <= '0;
      fwd_valid <= 1'b0;
    end else begin
      fwd_valid <= is_write;
      if (is_write) entry_vld[wr_addr] <= 1'b1;
    end
  end

  slot_entry_t chan_entry;
  always_comb begin
    if (fwd_valid && (fwd_addr == rd_addr)) chan_entry = fwd_data;
    else if (!entry_vld[rd_addr])           chan_entry = '{count: COUNT_RST,
                                                           preload: PRELOAD_RST};
    else                                    chan_entry = rd_data;
  end

  // ---------------- slot timer ----------------
  logic [COUNT_W-1:0] tick_timer, tick_timer_next;
  logic [COUNT_W-1:0] overflow_count, overflow_count_next;
  logic [SLOT_W-1:0]  slot_index_next;
  logic               pin_state, pin_state_next;

  logic [COUNT_W-1:0] slot_cnt, slot_pre;
  logic [COUNT_W:0]   ovf_inc;
  logic [SLOT_W-1:0]  slot_inc;

  always_comb begin
    if (slot_index == '0) begin
      // frame sync slot
      slot_cnt = frame_sync_count;
      slot_pre = '0;
    end else begin
      slot_cnt = chan_entry.count;
      slot_pre = chan_entry.preload;
    end
    ovf_inc  = {1'b0, overflow_count} + 9'd1;
    slot_inc = slot_index + 4'd1;

    tick_timer_next     = tick_timer;
    overflow_count_next = overflow_count;
    slot_index_next     = slot_index;
    pin_state_next      = pin_state;

    if (is_tick) begin
      tick_timer_next = tick_timer + 8'd1;
      if (tick_timer == '1) begin
        // timer wrap
        if (ovf_inc == {1'b0, slot_cnt}) begin
          overflow_count_next = ovf_inc[COUNT_W-1:0];
          tick_timer_next     = slot_pre;
        end else if (ovf_inc > {1'b0, slot_cnt}) begin
          // slot ends: next slot begins, pin set from its active-mask bit (low for frame sync)
          overflow_count_next = '0;
          tick_timer_next     = '0;
          pin_state_next      = 1'b0;
          if ({28'd0, slot_inc} > CHANNELS) begin
            slot_index_next = '0;
          end else begin
            slot_index_next = slot_inc;
            pin_state_next  = active_mask[3'(slot_inc - 4'd1)];
          end
        end else begin
          overflow_count_next = ovf_inc[COUNT_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_timer     <= '0;
      overflow_count <= '0;
      slot_index     <= '0;
      pin_state      <= 1'b0;
    end else begin
      tick_timer     <= tick_timer_next;
      overflow_count <= overflow_count_next;
      slot_index     <= slot_index_next;
      pin_state      <= pin_state_next;
    end
  end

  // ---------------- result output with skid word ----------------
  result_t res_new, out_word, skid_word;
  assign res_new = '{pin_level: pin_state_next, current_slot: slot_index_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_word   <= skid_word;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_word  <= res_new;
        out_valid <= in_acc;
      end
    end else if (in_acc) begin
      skid_word  <= res_new;
      skid_valid <= 1'b1;
    end
  end

  assign pin_level    = out_word.pin_level;
  assign current_slot = out_word.current_slot;

  // ---------------- assertions ----------------
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    {28'd0, slot_index} <= CHANNELS)
    else $error("slot index beyond channel count");

  a_sync_low: assert property (@(posedge clk) disable iff (rst)
    (slot_index == '0) |-> !pin_state)
    else $error("pin high during frame sync slot");

  a_skid_order: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid word held with empty output register");

  a_slot_start: assert property (@(posedge clk) disable iff (rst)
    (slot_index != $past(slot_index)) |-> (tick_timer == '0 && overflow_count == '0))
    else $error("new slot did not start from a cleared timer");

endmodule
